// ===== rtl/pbcp_pkg.sv =====
// ---------------------------------------------------------------------------
// pbcp_pkg
// Shared types and constants of the pixel to braille cell packer.
// ---------------------------------------------------------------------------
package pbcp_pkg;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [13:0] code_point;
      logic        end_of_line;
      logic        end_of_image;
   } rsp_type;

   typedef struct packed {
      logic       clear;
      logic [7:0] dots;
      logic       emit;
      logic       end_of_line;
      logic       end_of_image;
   } cmd_type;

   localparam logic [1:0] CSR_IMAGE_WIDTH    = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT   = 2'd1;
   localparam logic [1:0] CSR_DARK_THRESHOLD = 2'd2;

   localparam logic [10:0] RESET_IMAGE_WIDTH    = 11'd640;
   localparam logic [15:0] RESET_IMAGE_HEIGHT   = 16'd480;
   localparam logic [7:0]  RESET_DARK_THRESHOLD = 8'd127;

   localparam logic [13:0] BRAILLE_BASE = 14'h2800;
   localparam logic [7:0]  DOT_ONE      = 8'b00000001;
   localparam logic [1:0]  LAST_BAND_ROW = 2'd3;

   localparam int QUEUE_DEPTH = 4;

   function automatic logic [2:0] dot_shift(input logic [1:0] band_row, input logic odd_col);
      logic [2:0] shift;
      case (band_row)
         2'd0: shift = odd_col ? 3'd3 : 3'd0;
         2'd1: shift = odd_col ? 3'd4 : 3'd1;
         2'd2: shift = odd_col ? 3'd5 : 3'd2;
         default: shift = odd_col ? 3'd7 : 3'd6;
      endcase
      return shift;
   endfunction

endpackage

// ===== rtl/pbcp_front.sv =====
// ---------------------------------------------------------------------------
// pbcp_front
// Holds the configuration and the raster position, classifies each pixel
// and turns it into a cell update command for the back end.
// ---------------------------------------------------------------------------
module pbcp_front import pbcp_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        in_valid,
   input  req_type     in_data,
   output logic        in_ready,
   input  logic        push_ready,
   output logic        push_valid,
   output cmd_type     push_cmd,
   output logic [((MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) - 1 : 1) - 1:0] push_cell
);

   localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int AW = (CW > 1) ? CW - 1 : 1;

   logic [10:0]   image_width_ff;
   logic [15:0]   image_height_ff;
   logic [7:0]    dark_threshold_ff;
   logic [CW-1:0] col_ff, col_in;
   logic [15:0]   row_ff, row_in;

   logic [31:0]   width_ext;
   logic [CW-1:0] w_m1, x;
   logic [15:0]   h_m1, y;
   logic          last_col, last_row, dark, fire;
   logic [9:0]    pix_sum, thr3;
   logic [1:0]    band_row;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff    <= RESET_IMAGE_WIDTH;
         image_height_ff   <= RESET_IMAGE_HEIGHT;
         dark_threshold_ff <= RESET_DARK_THRESHOLD;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:    image_width_ff    <= csr_wdata[10:0];
            CSR_IMAGE_HEIGHT:   image_height_ff   <= csr_wdata;
            CSR_DARK_THRESHOLD: dark_threshold_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      width_ext = 32'(image_width_ff);
      if (image_width_ff == '0) begin
         w_m1 = '0;
      end else if (width_ext > 32'(MAX_WIDTH)) begin
         w_m1 = CW'(MAX_WIDTH - 1);
      end else begin
         w_m1 = CW'(width_ext - 32'd1);
      end
      h_m1 = (image_height_ff == '0) ? '0 : image_height_ff - 16'd1;
      x = (col_ff > w_m1) ? w_m1 : col_ff;
      y = (row_ff > h_m1) ? h_m1 : row_ff;
      last_col = (x == w_m1);
      last_row = (y == h_m1);
      band_row = y[1:0];

      pix_sum = {2'b00, in_data.red} + {2'b00, in_data.green} + {2'b00, in_data.blue};
      thr3 = {2'b00, dark_threshold_ff} + {1'b0, dark_threshold_ff, 1'b0};
      dark = (pix_sum < thr3);

      push_cmd.clear        = (band_row == 2'd0) && !x[0];
      push_cmd.dots         = dark ? (DOT_ONE << dot_shift(band_row, x[0])) : '0;
      push_cmd.emit         = ((band_row == LAST_BAND_ROW) || last_row) && (x[0] || last_col);
      push_cmd.end_of_line  = last_col;
      push_cmd.end_of_image = last_col && last_row;
      push_cell             = AW'(x >> 1);

      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : y + 16'd1;
      end else begin
         col_in = x + 1'b1;
         row_in = y;
      end
   end

   assign in_ready   = push_ready;
   assign push_valid = in_valid;
   assign fire       = in_valid && push_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (fire) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// ===== rtl/pbcp_queue.sv =====
// ---------------------------------------------------------------------------
// pbcp_queue
// Short first-in first-out queue of commands between front and back end.
// ---------------------------------------------------------------------------
module pbcp_queue import pbcp_pkg::*; #(
   parameter int DATA_W = 12,
   parameter int DEPTH  = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [DATA_W-1:0] in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [DATA_W-1:0] out_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0]     level_ff, level_in;
   logic              push, pop;

   assign in_ready  = (level_ff != LW'(DEPTH));
   assign out_valid = (level_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   level_in = level_ff + 1'b1;
         2'b01:   level_in = level_ff - 1'b1;
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ===== rtl/pbcp_back.sv =====
// ---------------------------------------------------------------------------
// pbcp_back
// Carries out cell update commands against the cell store and delivers
// each completed cell through an output register.
// ---------------------------------------------------------------------------
module pbcp_back import pbcp_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_ready,
   input  cmd_type cmd,
   input  logic [((MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) - 1 : 1) - 1:0] cmd_cell,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   localparam int CW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int AW    = (CW > 1) ? CW - 1 : 1;
   localparam int CELLS = (MAX_WIDTH + 1) / 2;

   logic [7:0]    cell_mem [CELLS];
   logic          r_valid_ff, r_valid_in;
   cmd_type       r_cmd_ff;
   logic [AW-1:0] r_cell_ff;
   logic [7:0]    rd_data_ff, byp_data_ff;
   logic          byp_ff;
   logic          out_valid_ff, out_valid_in;
   rsp_type       out_data_ff;
   logic          o_free, r_fire, take;
   logic [7:0]    base, cell_new;

   always_comb begin
      o_free    = !out_valid_ff || out_ready;
      r_fire    = r_valid_ff && (!r_cmd_ff.emit || o_free);
      cmd_ready = !r_valid_ff || r_fire;
      take      = cmd_valid && cmd_ready;
      base      = r_cmd_ff.clear ? '0 : (byp_ff ? byp_data_ff : rd_data_ff);
      cell_new  = base | r_cmd_ff.dots;

      r_valid_in = r_valid_ff;
      if (take) begin
         r_valid_in = 1'b1;
      end else if (r_fire) begin
         r_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (r_fire && r_cmd_ff.emit) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         r_valid_ff   <= r_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         r_cmd_ff    <= cmd;
         r_cell_ff   <= cmd_cell;
         byp_ff      <= r_fire && (r_cell_ff == cmd_cell);
         byp_data_ff <= cell_new;
      end
      if (r_fire && r_cmd_ff.emit) begin
         out_data_ff.code_point   <= BRAILLE_BASE + {6'b000000, cell_new};
         out_data_ff.end_of_line  <= r_cmd_ff.end_of_line;
         out_data_ff.end_of_image <= r_cmd_ff.end_of_image;
      end
   end

   always_ff @(posedge clock) begin
      if (r_fire) begin
         cell_mem[r_cell_ff] <= cell_new;
      end
      if (take) begin
         rd_data_ff <= cell_mem[cmd_cell];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

// ===== rtl/pixel_to_braille_cell_packer_unit.sv =====
// ---------------------------------------------------------------------------
// pixel_to_braille_cell_packer_unit
// Packs raster RGB pixels into Unicode braille cells of 2x4 dots.
// ---------------------------------------------------------------------------
// Pixels enter on the req_ channel in raster order, one beat per pixel.
// Each completed cell leaves on the rsp_ channel as one beat with its code
// point and the end of line and end of image flags; other pixels give none.
// The csr_ port sets image width, image height and dark threshold; the user
// must write it only while no pixel is in flight; the block does not check.
// The front end classifies a pixel in the cycle it is accepted and queues
// a command; the back end reads the cell store, merges the dot and writes
// it back, with a bypass for back to back updates of the same cell.
// A result passes the queue, the command register and the output register.
// One pixel is taken every cycle while the queue is not full.
// Reset clears the raster position, loads the register defaults and
// empties the queue and output stage; the cell store needs no clearing.
// When the receiver stalls, the output register holds its beat, the queue
// of four commands fills, and then req_ready drops.
// ---------------------------------------------------------------------------
module pixel_to_braille_cell_packer_unit import pbcp_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   localparam int CW     = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int AW     = (CW > 1) ? CW - 1 : 1;
   localparam int CMD_W  = $bits(cmd_type);
   localparam int DATA_W = CMD_W + AW;

   logic              push_valid, push_ready, pop_valid, pop_ready;
   cmd_type           push_cmd, pop_cmd;
   logic [AW-1:0]     push_cell, pop_cell;
   logic [DATA_W-1:0] push_data, pop_data;

   pbcp_front #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .in_valid     (req_valid),
      .in_data      (req_data),
      .in_ready     (req_ready),
      .push_ready   (push_ready),
      .push_valid   (push_valid),
      .push_cmd     (push_cmd),
      .push_cell    (push_cell)
   );

   assign push_data = {push_cell, push_cmd};

   pbcp_queue #(
      .DATA_W(DATA_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_data)
   );

   assign pop_cmd  = pop_data[CMD_W-1:0];
   assign pop_cell = pop_data[DATA_W-1:CMD_W];

   pbcp_back #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd_ready (pop_ready),
      .cmd       (pop_cmd),
      .cmd_cell  (pop_cell),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   a_reset_empties_output: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result valid right after reset.");

   a_image_end_ends_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.end_of_image |-> rsp_data.end_of_line)
      else $error("End of image without end of line.");

   a_braille_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.code_point[13:8] == BRAILLE_BASE[13:8])
      else $error("Code point outside the braille block.");

   a_queue_backpressure: assert property (@(posedge clock) disable iff (reset)
      pop_valid && !pop_ready |=> pop_valid && (pop_data == $past(pop_data)))
      else $error("Queued command lost while the back end stalled.");

endmodule
